/* hw/rtl/wah_pkg.sv */
// shared types, codes and reset values for the wall avoidance heading controller
`timescale 1ns / 1ps
`default_nettype none

package wah_pkg;

    localparam int FACE_COUNT = 4;
    localparam int ANGLE_BITS_DEF = 16;

    localparam logic [31:0] WALL_TAG = 32'h7761_6C6C;
    localparam logic [7:0]  MIN_TAG_LEN = 8'd4;
    localparam logic [15:0] LFSR_SEED = 16'hACE1;

    localparam logic [31:0] RST_WALL_MEMORY = 32'd300;
    localparam logic [31:0] RST_MAX_TURN = 32'd800;
    localparam logic [14:0] RST_ANGLE_TOL = 15'd1820;
    localparam logic [15:0] RST_FIXED_DELTA = 16'd16384;
    localparam logic [31:0] RST_COMMIT = 32'd700;

    typedef enum logic [1:0] {
        MODE_FORWARD = 2'd0,
        MODE_LEFT    = 2'd1,
        MODE_RIGHT   = 2'd2,
        MODE_COMMIT  = 2'd3
    } t_mode;

    typedef enum logic {
        OP_UPDATE  = 1'b0,
        OP_MESSAGE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        TGT_FIXED    = 2'd0,
        TGT_OPPOSITE = 2'd1,
        TGT_ORTHO    = 2'd2,
        TGT_SPARE    = 2'd3
    } t_tmode;

    typedef enum logic [1:0] {
        POL_CW     = 2'd0,
        POL_CCW    = 2'd1,
        POL_RANDOM = 2'd2,
        POL_MIN    = 2'd3
    } t_policy;

    typedef enum logic [2:0] {
        REG_WALL_MEMORY = 3'd0,
        REG_MAX_TURN    = 3'd1,
        REG_ANGLE_TOL   = 3'd2,
        REG_TARGET_MODE = 3'd3,
        REG_FIXED_DELTA = 3'd4,
        REG_COMMIT      = 3'd5,
        REG_TURN_POLICY = 3'd6,
        REG_ENABLED     = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [31:0]        wall_hold_ms;
        logic [31:0]        turn_limit_ms;
        logic [14:0]        angle_tolerance;
        t_tmode             aim_mode;
        logic signed [15:0] fixed_delta;
        logic [31:0]        commit_hold_ms;
        t_policy            turn_policy;
        logic               enabled;
    } t_cfg;

    typedef struct packed {
        t_op                operation;
        logic [31:0]        now_ms;
        logic signed [15:0] heading;
        logic [31:0]        payload_head;
        logic [7:0]         pay_len;
        logic [2:0]         receiver_face;
    } t_item;

endpackage

`default_nettype wire

/* hw/rtl/wall_avoid_heading_fsm_unit.sv */
// top level of the wall avoidance heading controller
//
//   channel   direction  payload
//   s_axis    in         tuser operation, tdata now/heading/payload/length/face
//   m_axis    out        tdata action/driving/accepted/active faces
//   cfg       in         register index and write data
//
// one beat is decided per cycle unless the output stalls: an input register feeds the face compares
// and the state machine, whose result lands in the output register
// the input stalls only when both registers hold beats and m_axis_tready is low
// reset is synchronous; it clears the faces, mode and target, loads the lfsr seed and reloads the config registers
`timescale 1ns / 1ps
`default_nettype none

module wall_avoid_heading_fsm_unit #(
    parameter int ANGLE_BITS = wah_pkg::ANGLE_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // now_ms, heading, payload_head, pay_len, receiver_face, zero pad
    input  wire logic [95:0] s_axis_tdata,
    // operation
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // action, driving, message_accepted, active_faces
    output logic [7:0]       m_axis_tdata,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    import wah_pkg::*;

    t_cfg                  cfg;
    t_item                 r_in;
    logic                  r_in_valid;
    logic                  r_out_valid;
    logic [7:0]            r_out_data;
    logic                  adv;
    logic                  accepted;
    logic [FACE_COUNT-1:0] mask_now, mask_after, mask_dec;
    t_mode                 mode;
    logic                  driving;

    assign adv = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;
    assign o_cfg_ready = 1'b1;

    wah_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    wah_faces u_faces (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fire           (adv),
        .i_item           (r_in),
        .i_wall_hold_ms   (cfg.wall_hold_ms),
        .o_accepted       (accepted),
        .o_mask_now       (mask_now),
        .o_mask_after     (mask_after)
    );

    assign mask_dec = mask_now;

    wah_decide #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_decide (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (adv),
        .i_item    (r_in),
        .i_cfg     (cfg),
        .i_mask    (mask_dec),
        .o_mode    (mode),
        .o_driving (driving)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.operation      <= t_op'(s_axis_tuser);
            r_in.now_ms         <= s_axis_tdata[31:0];
            r_in.heading        <= s_axis_tdata[47:32];
            r_in.payload_head   <= s_axis_tdata[79:48];
            r_in.pay_len        <= s_axis_tdata[87:80];
            r_in.receiver_face  <= s_axis_tdata[90:88];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data <= {mask_after, accepted, driving, mode};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata = r_out_data;

endmodule

`default_nettype wire

/* hw/rtl/wah_cfg_regs.sv */
// configuration register file
`timescale 1ns / 1ps
`default_nettype none

module wah_cfg_regs (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_valid,
    input  wire logic [2:0]      i_cfg_index,
    input  wire logic [31:0]     i_cfg_data,
    output wah_pkg::t_cfg        o_cfg
);
    import wah_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wall_hold_ms      <= RST_WALL_MEMORY;
            r_cfg.turn_limit_ms     <= RST_MAX_TURN;
            r_cfg.angle_tolerance   <= RST_ANGLE_TOL;
            r_cfg.aim_mode          <= TGT_ORTHO;
            r_cfg.fixed_delta       <= RST_FIXED_DELTA;
            r_cfg.commit_hold_ms    <= RST_COMMIT;
            r_cfg.turn_policy       <= POL_CW;
            r_cfg.enabled           <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_WALL_MEMORY: r_cfg.wall_hold_ms      <= i_cfg_data;
                REG_MAX_TURN:    r_cfg.turn_limit_ms     <= i_cfg_data;
                REG_ANGLE_TOL:   r_cfg.angle_tolerance   <= i_cfg_data[14:0];
                REG_TARGET_MODE: r_cfg.aim_mode          <= t_tmode'(i_cfg_data[1:0]);
                REG_FIXED_DELTA: r_cfg.fixed_delta       <= i_cfg_data[15:0];
                REG_COMMIT:      r_cfg.commit_hold_ms    <= i_cfg_data;
                REG_TURN_POLICY: r_cfg.turn_policy       <= t_policy'(i_cfg_data[1:0]);
                REG_ENABLED:     r_cfg.enabled           <= i_cfg_data[0];
                default:         r_cfg.enabled           <= r_cfg.enabled;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* hw/rtl/wah_faces.sv */
// face timestamps, wall tag check and active face masks
`timescale 1ns / 1ps
`default_nettype none

module wah_faces (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_fire,
    input  wire wah_pkg::t_item                i_item,
    input  wire logic [31:0]                   i_wall_hold_ms,
    output logic                               o_accepted,
    output logic [wah_pkg::FACE_COUNT-1:0]     o_mask_now,
    output logic [wah_pkg::FACE_COUNT-1:0]     o_mask_after
);
    import wah_pkg::*;

    logic [31:0] r_seen [FACE_COUNT];
    logic        wr_face;
    logic [1:0]  face_sel;
    logic [31:0] age [FACE_COUNT];

    assign o_accepted = (i_item.operation == OP_MESSAGE)
                      && (i_item.pay_len >= MIN_TAG_LEN)
                      && (i_item.payload_head == WALL_TAG);
    assign face_sel = i_item.receiver_face[1:0];
    assign wr_face = o_accepted && !i_item.receiver_face[2];

    always_comb begin
        for (int f = 0; f < FACE_COUNT; f++) begin
            age[f] = i_item.now_ms - r_seen[f];
            o_mask_now[f] = (r_seen[f] != 32'd0) && (age[f] <= i_wall_hold_ms);
        end
        o_mask_after = o_mask_now;
        if (wr_face) begin
            o_mask_after[face_sel] = (i_item.now_ms != 32'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int f = 0; f < FACE_COUNT; f++) begin
                r_seen[f] <= 32'd0;
            end
        end else if (i_fire && wr_face) begin
            r_seen[face_sel] <= i_item.now_ms;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/wah_decide.sv */
// action state machine with turn target, deadline and random side pick
`timescale 1ns / 1ps
`default_nettype none

module wah_decide #(
    parameter int ANGLE_BITS = wah_pkg::ANGLE_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_fire,
    input  wire wah_pkg::t_item                i_item,
    input  wire wah_pkg::t_cfg                 i_cfg,
    input  wire logic [wah_pkg::FACE_COUNT-1:0] i_mask,
    output wah_pkg::t_mode                     o_mode,
    output logic                               o_driving
);
    import wah_pkg::*;

    localparam logic [ANGLE_BITS-1:0] HALF_TURN = {1'b1, {(ANGLE_BITS-1){1'b0}}};
    localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = {2'b01, {(ANGLE_BITS-2){1'b0}}};

    t_mode                 r_mode, n_mode;
    logic                  r_tgt_valid, n_tgt_valid;
    logic [ANGLE_BITS-1:0] r_target, n_target;
    logic [31:0]           r_deadline, n_deadline;
    logic                  r_last_left, n_last_left;
    logic [15:0]           r_lfsr, n_lfsr;

    logic [31:0]           heading_ext, delta_ext;
    logic [ANGLE_BITS-1:0] h_ang, delta_ang, tgt_new, tgt, diff, mag;
    logic [31:0]           dl, mag_ext, tol_ext;
    logic                  front, right_on, left_on, surrounded, go_right, lfsr_fb;

    assign heading_ext = {{16{i_item.heading[15]}}, i_item.heading};
    assign delta_ext = {{16{i_cfg.fixed_delta[15]}}, i_cfg.fixed_delta};
    assign h_ang = heading_ext[ANGLE_BITS-1:0];
    assign delta_ang = delta_ext[ANGLE_BITS-1:0];

    always_comb begin
        case (i_cfg.aim_mode)
            TGT_OPPOSITE: tgt_new = h_ang + HALF_TURN;
            TGT_ORTHO:    tgt_new = (i_cfg.turn_policy == POL_CCW) ? h_ang - QUARTER_TURN
                                                                  : h_ang + QUARTER_TURN;
            default:      tgt_new = h_ang + delta_ang;
        endcase
    end

    assign tgt = r_tgt_valid ? r_target : tgt_new;
    assign dl = r_tgt_valid ? r_deadline : i_item.now_ms + i_cfg.turn_limit_ms;
    assign diff = tgt - h_ang;
    assign mag = (diff > HALF_TURN) ? (~diff + 1'b1) : diff;
    assign mag_ext = {{(32-ANGLE_BITS){1'b0}}, mag};
    assign tol_ext = {17'd0, i_cfg.angle_tolerance};

    assign front = i_mask[0];
    assign right_on = i_mask[1];
    assign left_on = i_mask[3];
    assign surrounded = ($countones(i_mask) >= 3);
    assign lfsr_fb = r_lfsr[0] ^ r_lfsr[2] ^ r_lfsr[3] ^ r_lfsr[5];

    always_comb begin
        case (i_cfg.turn_policy)
            POL_CW:     go_right = 1'b1;
            POL_CCW:    go_right = 1'b0;
            POL_RANDOM: go_right = r_lfsr[1];
            default: begin
                if (right_on && !left_on) begin
                    go_right = 1'b0;
                end else if (left_on && !right_on) begin
                    go_right = 1'b1;
                end else begin
                    go_right = r_last_left;
                end
            end
        endcase
    end

    // next state
    always_comb begin
        n_mode = r_mode;
        n_tgt_valid = r_tgt_valid;
        n_target = r_target;
        n_deadline = r_deadline;
        n_last_left = r_last_left;
        n_lfsr = r_lfsr;
        if (i_item.operation == OP_UPDATE && i_cfg.enabled) begin
            unique case (r_mode) inside
                MODE_LEFT, MODE_RIGHT: begin
                    if ((mag_ext <= tol_ext) || (i_item.now_ms >= dl)) begin
                        n_mode = MODE_COMMIT;
                        n_deadline = i_item.now_ms + i_cfg.commit_hold_ms;
                        n_tgt_valid = 1'b0;
                    end else begin
                        n_target = tgt;
                        n_deadline = dl;
                        n_tgt_valid = 1'b1;
                    end
                end
                MODE_COMMIT: begin
                    if ((i_mask == '0) && (i_item.now_ms >= r_deadline)) begin
                        n_mode = MODE_FORWARD;
                    end
                end
                MODE_FORWARD: begin
                    if (surrounded || front) begin
                        n_mode = go_right ? MODE_RIGHT : MODE_LEFT;
                        n_last_left = !go_right;
                        n_tgt_valid = 1'b0;
                        if (i_cfg.turn_policy == POL_RANDOM) begin
                            n_lfsr = {lfsr_fb, r_lfsr[15:1]};
                        end
                    end else if (left_on && !right_on) begin
                        n_mode = MODE_RIGHT;
                        n_last_left = 1'b0;
                        n_tgt_valid = 1'b0;
                    end else if (right_on && !left_on) begin
                        n_mode = MODE_LEFT;
                        n_last_left = 1'b1;
                        n_tgt_valid = 1'b0;
                    end
                end
                default: n_mode = r_mode;
            endcase
        end
    end

    // outputs
    always_comb begin
        o_mode = n_mode;
        o_driving = (i_item.operation == OP_UPDATE) && i_cfg.enabled
                  && (n_mode != MODE_FORWARD);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_FORWARD;
            r_tgt_valid <= 1'b0;
            r_target <= '0;
            r_deadline <= 32'd0;
            r_last_left <= 1'b0;
            r_lfsr <= LFSR_SEED;
        end else if (i_fire) begin
            r_mode <= n_mode;
            r_tgt_valid <= n_tgt_valid;
            r_target <= n_target;
            r_deadline <= n_deadline;
            r_last_left <= n_last_left;
            r_lfsr <= n_lfsr;
        end
    end

endmodule

`default_nettype wire
